>>> rtl/core/sorted_table_rank_select_unit_macros.svh
// Assertion macros for the sorted table unit.
`ifndef SORTED_TABLE_RANK_SELECT_UNIT_MACROS_SVH
`define SORTED_TABLE_RANK_SELECT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define STS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted table assertion failed");
`define STS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted table assertion failed");
`else
`define STS_ASSERT_IMP(lbl, ante, cons)
`define STS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/core/sts_pkg.sv
`default_nettype none
package sts_pkg;

	localparam int unsigned OPND_W   = 31;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned ECNT_W   = 9;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_RANK   = 2'd2,
		CMD_SELECT = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_EXEC = 1'b1
	} fsm_t;

	typedef struct packed {
		logic capture;
		logic ins;
		logic rem;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/sts_cell.sv
`default_nettype none
module sts_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CNT_W = 9
) (
	input  wire logic                          clk,
	input  wire sts_pkg::cell_ctl_t            ctl,
	input  wire logic [sts_pkg::OPND_W-1:0]    key,
	input  wire logic [sts_pkg::OPND_W-1:0]    ins_value,
	input  wire logic [CNT_W-1:0]              count,
	input  wire logic                          left_le,
	input  wire logic [sts_pkg::OPND_W-1:0]    left_entry,
	input  wire logic [sts_pkg::OPND_W-1:0]    right_entry,
	output logic      [sts_pkg::OPND_W-1:0]    entry_q,
	output logic                               lt_q,
	output logic                               le_q,
	output logic                               eq_q
);

	logic occ;

	assign occ = CNT_W'(INDEX) < count;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			lt_q <= occ && (entry_q < key);
			le_q <= occ && (entry_q <= key);
			eq_q <= occ && (entry_q == key);
		end
	end

	// shift right on insert, left on remove, beyond the boundary only
	always_ff @(posedge clk) begin
		if (ctl.ins && !le_q) begin
			entry_q <= left_le ? ins_value : left_entry;
		end else if (ctl.rem && !lt_q) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/sorted_table_rank_select_unit.sv
// Channel | Signals                                  | Direction
// request | in_valid, in_ready, command, operand     | in
// result  | out_valid, out_ready, status, answer,    | out
//         | entry_count                              |
// Per request, the accept edge loads compare flags into every cell of the chain;
// the edge that ends the execute state selects the result and shifts the chain.
// One request is in flight at a time; a new one is taken once the chain is updated.
// A result waiting in the output register stalls only the execute state.
// arst_n clears the internal entry count and control state; cells and result data need no reset.
`default_nettype none
`include "sorted_table_rank_select_unit_macros.svh"
module sorted_table_rank_select_unit #(
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      command,
	input  wire logic [sts_pkg::OPND_W-1:0]      operand,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [sts_pkg::STATUS_W-1:0]    status,
	output logic      [sts_pkg::OPND_W-1:0]      answer,
	output logic      [$clog2(DEPTH + 1)-1:0]    entry_count
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(DEPTH);

	sts_pkg::fsm_t      state_q, state_nxt;
	sts_pkg::cmd_t      cmd_q;
	sts_pkg::status_t   res_status;
	sts_pkg::cell_ctl_t ctl;

	logic [sts_pkg::OPND_W-1:0] opnd_q;
	logic [CNT_W-1:0]           count_q, count_nxt;
	logic                       out_valid_q;
	logic [sts_pkg::STATUS_W-1:0] status_q;
	logic [sts_pkg::OPND_W-1:0] answer_q, res_answer;
	logic [CNT_W-1:0]           ecnt_q;
	logic                       accept, exec_go;

	logic [sts_pkg::OPND_W-1:0] entry_w       [DEPTH];
	logic [sts_pkg::OPND_W-1:0] left_entry_w  [DEPTH];
	logic [sts_pkg::OPND_W-1:0] right_entry_w [DEPTH];
	logic [DEPTH-1:0]           lt_w, le_w, eq_w, left_le_w, bound_w;

	logic                       found, full, sel_ok;
	logic [IDX_W-1:0]           rank_idx, sel_idx;
	logic [sts_pkg::OPND_W-1:0] sel_pos, sel_val;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign left_le_w[g]    = 1'b1;
			assign left_entry_w[g] = entry_w[g];
		end else begin : g_body
			assign left_le_w[g]    = le_w[g-1];
			assign left_entry_w[g] = entry_w[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign right_entry_w[g] = entry_w[g];
		end else begin : g_next
			assign right_entry_w[g] = entry_w[g+1];
		end

		sts_cell #(
			.INDEX(g),
			.CNT_W(CNT_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.key        (operand),
			.ins_value  (opnd_q),
			.count      (count_q),
			.left_le    (left_le_w[g]),
			.left_entry (left_entry_w[g]),
			.right_entry(right_entry_w[g]),
			.entry_q    (entry_w[g]),
			.lt_q       (lt_w[g]),
			.le_q       (le_w[g]),
			.eq_q       (eq_w[g])
		);
	end

	assign accept  = in_valid && in_ready;
	assign found   = |eq_w;
	assign full    = count_q == CNT_W'(DEPTH);
	assign bound_w = ~lt_w & {lt_w[DEPTH-2:0], 1'b1};
	assign sel_ok  = (opnd_q != '0) && (opnd_q <= sts_pkg::OPND_W'(count_q));
	assign sel_pos = opnd_q - sts_pkg::OPND_W'(1);
	assign sel_idx = sel_pos[IDX_W-1:0];

	always_comb begin
		rank_idx = '0;
		sel_val  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (bound_w[i]) begin
				rank_idx = rank_idx | IDX_W'(i);
			end
			if (IDX_W'(i) == sel_idx) begin
				sel_val = sel_val | entry_w[i];
			end
		end
	end

	always_comb begin
		res_status = sts_pkg::ST_DONE;
		res_answer = '0;
		count_nxt  = count_q;
		ctl        = '0;
		ctl.capture = accept;
		case (cmd_q)
			sts_pkg::CMD_INSERT: begin
				if (full) begin
					res_status = sts_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + CNT_W'(1);
					ctl.ins   = exec_go;
				end
			end
			sts_pkg::CMD_REMOVE: begin
				if (found) begin
					count_nxt = count_q - CNT_W'(1);
					ctl.rem   = exec_go;
				end else begin
					res_status = sts_pkg::ST_NOT_FOUND;
				end
			end
			sts_pkg::CMD_RANK: begin
				if (found) begin
					res_answer = sts_pkg::OPND_W'(rank_idx) + sts_pkg::OPND_W'(1);
				end else begin
					res_status = sts_pkg::ST_NOT_FOUND;
				end
			end
			sts_pkg::CMD_SELECT: begin
				if (sel_ok) begin
					res_answer = sel_val;
				end else begin
					res_status = sts_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				res_status = sts_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sts_pkg::FSM_IDLE: begin
				if (in_valid) begin
					state_nxt = sts_pkg::FSM_EXEC;
				end
			end
			sts_pkg::FSM_EXEC: begin
				if (exec_go) begin
					state_nxt = sts_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_nxt = sts_pkg::FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		exec_go  = 1'b0;
		case (state_q)
			sts_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
			end
			sts_pkg::FSM_EXEC: begin
				exec_go = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sts_pkg::FSM_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (exec_go) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= sts_pkg::cmd_t'(command);
			opnd_q <= operand;
		end
		if (exec_go) begin
			status_q <= res_status;
			answer_q <= res_answer;
			ecnt_q   <= count_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign answer      = answer_q;
	assign entry_count = ecnt_q;

	`STS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH))
	`STS_ASSERT_NXT(a_accept_exec, accept, state_q == sts_pkg::FSM_EXEC)
	`STS_ASSERT_NXT(a_exec_result, exec_go, out_valid_q)
	`STS_ASSERT_NXT(a_full_hold, exec_go && cmd_q == sts_pkg::CMD_INSERT && full, count_q == $past(count_q))

endmodule
`default_nettype wire

>>> tb/sorted_table_rank_select_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module sorted_table_rank_select_unit_tb;

	localparam int unsigned TABLE_DEPTH    = 256;
	localparam int unsigned PHASE_ITEMS    = 630;
	localparam int unsigned HOLD_CYCLES    = 200;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES  = 10;

	typedef struct {
		sts_pkg::status_t            status;
		logic [sts_pkg::OPND_W-1:0]  answer;
		logic [sts_pkg::ECNT_W-1:0]  count;
	} response_t;

	typedef enum {MODE_GROW, MODE_MIXED, MODE_DRAIN} fill_mode_t;

	class table_scoreboard;
		logic [sts_pkg::OPND_W-1:0] entries[$];
		response_t                  expected_responses[$];
		int unsigned                mismatches;

		function int unsigned count_below(logic [sts_pkg::OPND_W-1:0] value);
			int unsigned n;
			n = 0;
			foreach (entries[i]) if (entries[i] < value) n++;
			return n;
		endfunction

		function int unsigned count_not_above(logic [sts_pkg::OPND_W-1:0] value);
			int unsigned n;
			n = 0;
			foreach (entries[i]) if (entries[i] <= value) n++;
			return n;
		endfunction

		function void note_request(sts_pkg::cmd_t cmd, logic [sts_pkg::OPND_W-1:0] value);
			response_t   resp;
			int unsigned pos;
			resp.status = sts_pkg::ST_DONE;
			resp.answer = '0;
			case (cmd)
			sts_pkg::CMD_INSERT: begin
				if (entries.size() >= TABLE_DEPTH) begin
					resp.status = sts_pkg::ST_FULL;
				end else begin
					pos = count_not_above(value);
					entries.insert(pos, value);
				end
			end
			sts_pkg::CMD_REMOVE: begin
				pos = count_below(value);
				if (pos < entries.size() && entries[pos] == value) entries.delete(pos);
				else resp.status = sts_pkg::ST_NOT_FOUND;
			end
			sts_pkg::CMD_RANK: begin
				pos = count_below(value);
				if (pos < entries.size() && entries[pos] == value)
					resp.answer = sts_pkg::OPND_W'(pos + 1);
				else resp.status = sts_pkg::ST_NOT_FOUND;
			end
			default: begin
				if (value >= 1 && value <= entries.size()) resp.answer = entries[value - 1];
				else resp.status = sts_pkg::ST_NOT_FOUND;
			end
			endcase
			resp.count = sts_pkg::ECNT_W'(entries.size());
			expected_responses.push_back(resp);
		endfunction

		function void check_result(sts_pkg::status_t st, logic [sts_pkg::OPND_W-1:0] ans,
				logic [sts_pkg::ECNT_W-1:0] cnt);
			response_t exp_resp;
			if (expected_responses.size() == 0) begin
				$display("%0t: unrequested result: status %0d answer %0d count %0d",
					$time, st, ans, cnt);
				mismatches++;
				return;
			end
			exp_resp = expected_responses.pop_front();
			if (st !== exp_resp.status) begin
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, exp_resp.status, st);
				mismatches++;
			end
			if (ans !== exp_resp.answer) begin
				$display("%0t: answer mismatch: expected %0d, got %0d",
					$time, exp_resp.answer, ans);
				mismatches++;
			end
			if (cnt !== exp_resp.count) begin
				$display("%0t: entry count mismatch: expected %0d, got %0d",
					$time, exp_resp.count, cnt);
				mismatches++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	logic [1:0]                   command;
	logic [sts_pkg::OPND_W-1:0]   operand;
	logic                         out_valid;
	logic                         out_ready;
	logic [sts_pkg::STATUS_W-1:0] status;
	logic [sts_pkg::OPND_W-1:0]   answer;
	logic [sts_pkg::ECNT_W-1:0]   entry_count;

	table_scoreboard sb = new();
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;
	bit              hold_off_pending;
	int unsigned     idle_cycles = 0;

	sorted_table_rank_select_unit #(
		.DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.operand(operand),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.answer(answer),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_request(sts_pkg::cmd_t'(command), operand);
		if (arst_n && out_valid && out_ready)
			sb.check_result(sts_pkg::status_t'(status), answer, entry_count);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(input sts_pkg::cmd_t cmd,
			input logic [sts_pkg::OPND_W-1:0] value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		operand  <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [sts_pkg::OPND_W-1:0] pick_value();
		int unsigned roll;
		logic [31:0] raw;
		roll = $urandom_range(0, 99);
		raw  = $urandom();
		if (roll < 40 && sb.entries.size() > 0)
			return sb.entries[$urandom_range(0, sb.entries.size() - 1)];
		if (roll < 75) return sts_pkg::OPND_W'($urandom_range(0, 63));
		if (roll < 85) begin
			case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return {{(sts_pkg::OPND_W-1){1'b1}}, 1'b0};
			default: return sts_pkg::OPND_W'(1);
			endcase
		end
		return raw[sts_pkg::OPND_W-1:0];
	endfunction

	function automatic logic [sts_pkg::OPND_W-1:0] pick_position();
		int unsigned roll;
		int unsigned fill;
		logic [31:0] raw;
		roll = $urandom_range(0, 99);
		fill = sb.entries.size();
		raw  = $urandom();
		if (roll < 70 && fill > 0) return sts_pkg::OPND_W'($urandom_range(1, fill));
		if (roll < 80) return '0;
		if (roll < 90) return sts_pkg::OPND_W'(fill + 1);
		return raw[sts_pkg::OPND_W-1:0];
	endfunction

	initial begin
		int unsigned phase;
		int unsigned item;
		int unsigned roll;
		int unsigned mode_len;
		fill_mode_t  mode;
		sts_pkg::cmd_t cmd;
		logic [sts_pkg::OPND_W-1:0] value;

		arst_n           = 1'b0;
		in_valid         = 1'b0;
		command          = sts_pkg::CMD_INSERT;
		operand          = '0;
		hold_off_pending = 1'b0;
		send_idle_pct    = 23;
		recv_idle_pct    = 58;
		mode             = MODE_GROW;
		mode_len         = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(sts_pkg::CMD_SELECT, sts_pkg::OPND_W'(1));
		send_request(sts_pkg::CMD_RANK, '0);
		send_request(sts_pkg::CMD_REMOVE, sts_pkg::OPND_W'(5));
		send_request(sts_pkg::CMD_INSERT, '0);
		send_request(sts_pkg::CMD_INSERT, '1);
		send_request(sts_pkg::CMD_INSERT, sts_pkg::OPND_W'(7));
		send_request(sts_pkg::CMD_INSERT, sts_pkg::OPND_W'(7));
		send_request(sts_pkg::CMD_INSERT, sts_pkg::OPND_W'(7));
		send_request(sts_pkg::CMD_RANK, sts_pkg::OPND_W'(7));
		send_request(sts_pkg::CMD_RANK, '0);
		send_request(sts_pkg::CMD_RANK, '1);
		send_request(sts_pkg::CMD_RANK, sts_pkg::OPND_W'(8));
		send_request(sts_pkg::CMD_SELECT, '0);
		send_request(sts_pkg::CMD_SELECT, sts_pkg::OPND_W'(6));
		send_request(sts_pkg::CMD_SELECT, sts_pkg::OPND_W'(7));
		send_request(sts_pkg::CMD_SELECT, '1);
		send_request(sts_pkg::CMD_SELECT, sts_pkg::OPND_W'(1));
		send_request(sts_pkg::CMD_REMOVE, sts_pkg::OPND_W'(7));
		send_request(sts_pkg::CMD_REMOVE, sts_pkg::OPND_W'(6));
		send_request(sts_pkg::CMD_REMOVE, '0);
		send_request(sts_pkg::CMD_REMOVE, '1);
		send_request(sts_pkg::CMD_SELECT, sts_pkg::OPND_W'(2));

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
			0: begin send_idle_pct = 23; recv_idle_pct = 58; end
			1: begin send_idle_pct = 58; recv_idle_pct = 23; end
			default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (item = 0; item < PHASE_ITEMS; item++) begin
				if (phase == 0 && item == 150) hold_off_pending = 1'b1;
				mode_len++;
				case (mode)
				MODE_GROW: begin
					if (sb.entries.size() < TABLE_DEPTH) mode_len = 0;
					else if (mode_len > 25) begin mode = MODE_MIXED; mode_len = 0; end
				end
				MODE_MIXED: begin
					if (mode_len > 80) begin mode = MODE_DRAIN; mode_len = 0; end
				end
				default: begin
					if (sb.entries.size() > 0) mode_len = 0;
					else if (mode_len > 15) begin mode = MODE_GROW; mode_len = 0; end
				end
				endcase
				roll = $urandom_range(0, 99);
				case (mode)
				MODE_GROW:
					cmd = (roll < 80) ? sts_pkg::CMD_INSERT :
						(roll < 85) ? sts_pkg::CMD_REMOVE :
						(roll < 93) ? sts_pkg::CMD_RANK : sts_pkg::CMD_SELECT;
				MODE_MIXED:
					cmd = sts_pkg::cmd_t'(roll % 4);
				default:
					cmd = (roll < 10) ? sts_pkg::CMD_INSERT :
						(roll < 70) ? sts_pkg::CMD_REMOVE :
						(roll < 85) ? sts_pkg::CMD_RANK : sts_pkg::CMD_SELECT;
				endcase
				value = (cmd == sts_pkg::CMD_SELECT) ? pick_position() : pick_value();
				send_request(cmd, value);
			end
		end
		in_valid <= 1'b0;

		while (sb.expected_responses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/sts_pkg.sv
rtl/core/sts_cell.sv
rtl/core/sorted_table_rank_select_unit.sv
tb/sorted_table_rank_select_unit_tb.sv
